FILE: src/ais_pkg.sv
// Shared types for the ascending integer sorter.
// Holds the element type and the per-cell control group.
// No dependencies.
package ais_pkg;

    // Width of one element
    localparam int unsigned VALUE_W = 32;

    // One element, two's complement
    typedef logic signed [VALUE_W-1:0] t_value;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the new element, shift larger ones right
        logic shift;    // move every element one cell towards the head
    } t_cell_ctrl;

endpackage

FILE: src/ais_if.sv
// Request channels of the ascending integer sorter.
// Depends on ais_pkg for the element type.
interface ais_in_if;
    logic              valid;
    logic              ready;
    ais_pkg::t_value   value;
    logic              is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ais_out_if;
    logic              valid;
    logic              ready;
    ais_pkg::t_value   sorted_value;
    logic              end_of_run;
    logic              dropped;

    modport source (output valid, output sorted_value, output end_of_run,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input dropped, output ready);
endinterface

FILE: src/ais_cell.sv
// One cell of the sorting chain: holds one element and its valid bit.
// Depends on ais_pkg for the element type and the control group.
module ais_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ais_pkg::t_cell_ctrl i_ctrl,
    input  ais_pkg::t_value     i_new_value,
    input  ais_pkg::t_value     i_left_value,
    input  logic                i_left_valid,
    input  logic                i_left_gt,
    input  ais_pkg::t_value     i_right_value,
    input  logic                i_right_valid,
    output ais_pkg::t_value     o_value,
    output logic                o_valid,
    output logic                o_gt
);

    ais_pkg::t_value r_value;
    ais_pkg::t_value n_value;
    logic            r_valid;
    logic            n_valid;

    // Flag an empty cell or one holding a larger element than the new one
    assign o_gt = !r_valid || (r_value > i_new_value);

    // Choose the next content: insert, drain shift or hold
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.insert && o_gt) begin
            if (i_left_gt) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

FILE: src/ascending_integer_sorter_core.sv
// Top level of the ascending integer sorter: a chain of DEPTH sorting cells.
// Depends on ais_pkg, ais_if (ais_in_if, ais_out_if) and ais_cell.
//
// Usage:
//   i_in carries one signed element per request, with is_last on the final
//   one of a run. Elements are inserted in sorted place as they arrive, one
//   request per cycle, and give no result. Elements that arrive while all
//   DEPTH cells are full are dropped and set the dropped flag.
//   The request carrying is_last closes the run. From the next cycle o_out
//   presents the stored elements in ascending order, one per cycle while the
//   receiver is ready; end_of_run marks the final one and dropped is the
//   same on every result of the run. i_in is not ready while a run drains.
//   Each cycle is bounded by the broadcast compare of the new element in
//   every cell. A stall on o_out holds the head element and the whole chain.
//   Reset empties every cell and clears the dropped flag; the block is
//   ready for a new run as soon as reset is released.
module ascending_integer_sorter_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ais_in_if.sink         i_in,
    ais_out_if.source      o_out
);

    ais_pkg::t_value     w_value [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_gt;
    ais_pkg::t_cell_ctrl w_ctrl;

    logic r_draining;
    logic r_dropped;
    logic w_in_accept;
    logic w_out_accept;
    logic w_full;

    // Chain is full when its tail cell holds an element
    assign w_full       = w_valid[DEPTH-1];
    assign w_in_accept  = i_in.valid && i_in.ready;
    assign w_out_accept = o_out.valid && o_out.ready;

    // Insert while loading, shift towards the head as results are taken
    assign w_ctrl.insert = w_in_accept && !w_full;
    assign w_ctrl.shift  = w_out_accept;

    // Build the chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ais_pkg::t_value w_left_value;
        logic            w_left_valid;
        logic            w_left_gt;
        ais_pkg::t_value w_right_value;
        logic            w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_valid = 1'b0;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        ais_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_value   (i_in.value),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Track the drain phase and the sticky drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            if (w_out_accept && o_out.end_of_run) begin
                r_draining <= 1'b0;
                r_dropped  <= 1'b0;
            end else begin
                if (w_in_accept && i_in.is_last) begin
                    r_draining <= 1'b1;
                end
                if (w_in_accept && w_full) begin
                    r_dropped <= 1'b1;
                end
            end
        end
    end

    // Drive the channels
    assign i_in.ready         = !r_draining;
    assign o_out.valid        = r_draining && w_valid[0];
    assign o_out.sorted_value = w_value[0];
    assign o_out.end_of_run   = !w_valid[1];
    assign o_out.dropped      = r_dropped;

`ifndef NO_ASSERTIONS
    // Occupied cells form an unbroken run from the head
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[DEPTH-1:1] & ~w_valid[DEPTH-2:0]) == '0)
        else $error("gap in occupied cells");

    // Successive results of a run never decrease
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_accept && !o_out.end_of_run) |=>
            (o_out.valid && (o_out.sorted_value >= $past(o_out.sorted_value))))
        else $error("results out of order");

    // A closing request always yields a result on the next cycle
    a_close_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in.is_last) |=> o_out.valid)
        else $error("closed run gives no result");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for ascending_integer_sorter_core: streams runs of signed elements
// and checks every sorted result against a local sort of the same run.
// Depends on ais_pkg, ais_if and the sorter RTL.
module tb_top;

    localparam int unsigned     DEPTH       = 64;
    localparam int unsigned     CYCLE_LIMIT = 200000;
    localparam int unsigned     LONG_STALL  = 200;
    localparam int unsigned     MAX_REPORTS = 10;
    localparam ais_pkg::t_value VAL_MAX     = {1'b0, {(ais_pkg::VALUE_W-1){1'b1}}};
    localparam ais_pkg::t_value VAL_MIN     = {1'b1, {(ais_pkg::VALUE_W-1){1'b0}}};

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_MIXED} t_value_mode;

    typedef struct {
        ais_pkg::t_value value;
        bit              is_last;
    } t_element_req;

    typedef struct {
        ais_pkg::t_value sorted_value;
        bit              end_of_run;
        bit              dropped;
    } t_sorted_result;

    logic clk = 1'b0;
    logic rst_n;

    ais_in_if  in_if();
    ais_out_if out_if();

    ascending_integer_sorter_core #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Requests waiting to be offered, and sorted results still owed
    t_element_req   pending_elements[$];
    t_sorted_result expected_sorted[$];

    // Local copy of the sorter state
    ais_pkg::t_value held_elements[DEPTH];
    int unsigned     held_count;
    bit              run_overflow;

    bit          req_taken;
    bit          calm;
    bit          stall_armed;
    int unsigned stall_left;
    int unsigned requests_queued;
    int unsigned requests_accepted;
    int unsigned runs_closed;
    int unsigned runs_dropped;
    int unsigned long_stalls;
    int unsigned results_checked;
    int unsigned mismatches;

    always #5 clk = ~clk;

    // Store one accepted element; on the closing one sort the run and owe its results
    function automatic void absorb_element(ais_pkg::t_value value, bit is_last);
        ais_pkg::t_value key;
        int              j;
        t_sorted_result  res;
        if (held_count < DEPTH) begin
            held_elements[held_count] = value;
            held_count++;
        end else begin
            run_overflow = 1'b1;
        end
        if (!is_last) return;
        for (int i = 1; i < held_count; i++) begin
            key = held_elements[i];
            j   = i;
            while (j > 0 && held_elements[j-1] > key) begin
                held_elements[j] = held_elements[j-1];
                j--;
            end
            held_elements[j] = key;
        end
        for (int k = 0; k < held_count; k++) begin
            res.sorted_value = held_elements[k];
            res.end_of_run   = (k == held_count - 1);
            res.dropped      = run_overflow;
            expected_sorted.push_back(res);
        end
        runs_closed++;
        if (run_overflow) runs_dropped++;
        held_count   = 0;
        run_overflow = 1'b0;
    endfunction

    function automatic ais_pkg::t_value pick_element(t_value_mode mode);
        case (mode)
            VAL_NARROW: return ais_pkg::t_value'(int'($urandom_range(6)) - 3);
            VAL_EXTREME: begin
                case ($urandom_range(3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            VAL_MIXED: return pick_element(t_value_mode'($urandom_range(2)));
            default:   return ais_pkg::t_value'($urandom);
        endcase
    endfunction

    task automatic queue_element(ais_pkg::t_value value, bit is_last);
        t_element_req req;
        req.value   = value;
        req.is_last = is_last;
        pending_elements.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_run(int unsigned len, t_value_mode mode);
        for (int unsigned i = 0; i < len; i++)
            queue_element(pick_element(mode), i == len - 1);
    endtask

    task automatic queue_short_runs(int unsigned target);
        int unsigned first;
        first = requests_queued;
        while (requests_queued - first < target)
            queue_run($urandom_range(8, 1), VAL_MIXED);
    endtask

    // Hold off until every request is taken and every owed result has arrived
    task automatic wait_drained();
        while (requests_accepted != requests_queued) @(posedge clk);
        while (expected_sorted.size() != 0) @(posedge clk);
    endtask

    // Capture accepted requests and feed them to the local sort
    always @(posedge clk) begin : request_capture
        req_taken = rst_n && in_if.valid && in_if.ready;
        if (req_taken) begin
            absorb_element(in_if.value, in_if.is_last);
            requests_accepted++;
        end
    end

    // Offer queued requests at the falling edge, with random gaps
    always @(negedge clk) begin : request_driver
        t_element_req nxt;
        bit           offer;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || req_taken) begin
            // advance only once the current request has been taken
            offer = (pending_elements.size() != 0) && (calm || $urandom_range(99) >= 10);
            if (offer) begin
                nxt = pending_elements.pop_front();
                in_if.value   <= nxt.value;
                in_if.is_last <= nxt.is_last;
            end
            in_if.valid <= offer;
        end
    end

    // Drive receiver readiness: random gaps, plus one long hold-off on request
    always @(negedge clk) begin : result_sink
        bit rdy;
        if (stall_armed && out_if.valid) begin
            stall_left  = LONG_STALL;
            stall_armed = 1'b0;
            long_stalls++;
        end
        if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = calm || $urandom_range(99) >= 10;
        end
        out_if.ready <= rdy;
    end

    // Compare each accepted result with the oldest owed one
    always @(posedge clk) begin : result_monitor
        t_sorted_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_sorted.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %0d end %0b dropped %0b",
                             out_if.sorted_value, out_if.end_of_run, out_if.dropped);
            end else begin
                want = expected_sorted.pop_front();
                results_checked++;
                if (out_if.sorted_value !== want.sorted_value ||
                    out_if.end_of_run !== want.end_of_run ||
                    out_if.dropped !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 results_checked, want.sorted_value, want.end_of_run,
                                 want.dropped, out_if.sorted_value, out_if.end_of_run,
                                 out_if.dropped);
                end
            end
        end
    end

    // Guard against a hung run
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        in_if.valid   = 1'b0;
        in_if.value   = '0;
        in_if.is_last = 1'b0;
        out_if.ready  = 1'b0;
        rst_n         = 1'b0;
        held_count    = 0;
        run_overflow  = 1'b0;
        calm          = 1'b0;
        stall_armed   = 1'b0;
        stall_left    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extremes of the value range together with zero and its neighbours
        queue_element(VAL_MAX, 1'b0);
        queue_element(VAL_MIN, 1'b0);
        queue_element('0, 1'b0);
        queue_element('1, 1'b0);
        queue_element(ais_pkg::t_value'(1), 1'b1);
        // Single-element run
        queue_element(ais_pkg::t_value'(-7), 1'b1);
        // Duplicates stay adjacent
        queue_element(ais_pkg::t_value'(5), 1'b0);
        queue_element(ais_pkg::t_value'(-5), 1'b0);
        queue_element(ais_pkg::t_value'(5), 1'b0);
        queue_element(ais_pkg::t_value'(5), 1'b1);
        // Already ascending, then strictly descending
        for (int i = -3; i <= 0; i++) queue_element(ais_pkg::t_value'(i), i == 0);
        queue_element(ais_pkg::t_value'(100), 1'b0);
        queue_element(ais_pkg::t_value'(50), 1'b0);
        queue_element(ais_pkg::t_value'(-50), 1'b0);
        queue_element(ais_pkg::t_value'(-100), 1'b1);
        // Equal extremes, then a lone maximum
        queue_element(VAL_MIN, 1'b0);
        queue_element(VAL_MIN, 1'b1);
        queue_element(VAL_MAX, 1'b1);

        // Short random runs under normal idling
        queue_short_runs(25);
        wait_drained();

        // Store exactly full: nothing is dropped
        queue_run(DEPTH, VAL_MIXED);
        wait_drained();

        // Overflow run whose closing element is dropped too; the receiver
        // holds off while the next runs are already being offered
        stall_armed = 1'b1;
        queue_run(DEPTH + 2, VAL_FULL);
        queue_short_runs(15);
        wait_drained();

        // Stretch with no idling on either side
        calm = 1'b1;
        queue_short_runs(20);
        wait_drained();
        calm = 1'b0;

        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        $display("Covered %0d runs from %0d requests, %0d of them with dropped elements,",
                 runs_closed, requests_accepted, runs_dropped);
        $display("%0d long receiver stall(s); checked %0d sorted results, %0d mismatches",
                 long_stalls, results_checked, mismatches);
        if (mismatches == 0 && expected_sorted.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
